[hdl/modular_exponentiation_core_macros.svh]
// Assertion macros shared by the modular exponentiation core and its multiplier
`ifndef MODULAR_EXPONENTIATION_CORE_MACROS_SVH
`define MODULAR_EXPONENTIATION_CORE_MACROS_SVH

// Same-cycle implication, reset masks the check
`define MXP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, reset masks the check
`define MXP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/mxp_pkg.sv]
// Package: request/response payload types and multiplier control types
`timescale 1ns / 1ps

package mxp_pkg;

   localparam int DATA_W = 32;

   typedef struct packed {
      logic [DATA_W-1:0] base_value;
      logic [DATA_W-1:0] exponent;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0] power_result;
      logic              modulus_error;
   } rsp_type;

   typedef struct packed {
      logic start;
   } mul_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } mul_sts_type;

endpackage

[hdl/modular_exponentiation_core.sv]
// Top level: modular exponentiation sequencer around a shared modular multiplier
`timescale 1ns / 1ps

`include "modular_exponentiation_core_macros.svh"

// Channel   | Ports                         | Handshake
// ----------+-------------------------------+------------------------------------
// request   | start, busy, req_data         | taken on start high and busy low
// response  | rsp_valid, rsp_data           | one-cycle strobe, no back-pressure
// config    | csr_wr_en, csr_wr_data        | modulus written when csr_wr_en high
//
// Every modular product goes through the one bit-serial multiplier. A clear exponent bit
// takes a square only, a set bit below the top one a multiply, then a square, and the
// top set bit a multiply only. The worst case for the time busy is high is an all-ones
// exponent. A zero modulus answers in the cycle after acceptance with the error flag set,
// busy low. Reset is synchronous and sets the modulus to 1; busy is high from acceptance
// until the response strobe, and the receiver cannot stall the response.

module modular_exponentiation_core #(
   parameter int WIDTH = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  mxp_pkg::req_type            req_data,
   output logic                        rsp_valid,
   output mxp_pkg::rsp_type            rsp_data,
   input  logic                        csr_wr_en,
   input  logic [mxp_pkg::DATA_W-1:0]  csr_wr_data
);
   import mxp_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_REDUCE = 5'b00010,
      ST_NEXT   = 5'b00100,
      ST_MULT   = 5'b01000,
      ST_SQUARE = 5'b10000
   } state_type;

   state_type        state_ff, state_in;
   logic [WIDTH-1:0] modulus_ff, modulus_in;
   logic [WIDTH-1:0] exp_ff, exp_in;
   logic [WIDTH-1:0] base_ff, base_in;
   logic [WIDTH-1:0] acc_ff, acc_in;
   rsp_type          rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;

   mul_ctl_type      mul_ctl;
   mul_sts_type      mul_sts;
   logic [WIDTH-1:0] mul_a;
   logic [WIDTH-1:0] mul_b;
   logic [WIDTH-1:0] mul_res;
   logic [WIDTH-1:0] exp_rest;
   logic [WIDTH-1:0] acc_seed;

   logic             run_accept;
   logic             mul_wait;
   logic             rsp_err;

   // Shared multiplier: reduction of the base, products and squares
   mxp_mulmod #(
      .WIDTH (WIDTH)
   ) u_mulmod (
      .clock   (clock),
      .reset   (reset),
      .ctl     (mul_ctl),
      .opa     (mul_a),
      .opb     (mul_b),
      .modulus (modulus_ff),
      .sts     (mul_sts),
      .result  (mul_res)
   );

   // Exponent bits still to scan once the current one is done
   assign exp_rest = exp_ff >> 1;
   // 1 mod m: zero only for a modulus of one
   assign acc_seed = (modulus_ff == WIDTH'(1)) ? '0 : WIDTH'(1);

   // Modulus register, masked to the operand width
   always_comb begin
      modulus_in = modulus_ff;
      if (csr_wr_en) begin
         modulus_in = WIDTH'(csr_wr_data);
      end
   end

   always_comb begin
      state_in     = state_ff;
      exp_in       = exp_ff;
      base_in      = base_ff;
      acc_in       = acc_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      mul_ctl.start = 1'b0;
      mul_a        = acc_ff;
      mul_b        = base_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               exp_in = WIDTH'(req_data.exponent);
               if (modulus_ff == '0) begin
                  // Zero modulus: flag it and answer straight away
                  rsp_in.power_result  = '0;
                  rsp_in.modulus_error = 1'b1;
                  rsp_valid_in         = 1'b1;
               end else begin
                  // Reduce the base as 1 * base mod m
                  mul_ctl.start = 1'b1;
                  mul_a         = acc_seed;
                  mul_b         = WIDTH'(req_data.base_value);
                  state_in      = ST_REDUCE;
               end
            end
         end
         ST_REDUCE: begin
            if (mul_sts.done) begin
               base_in = mul_res;
               acc_in  = acc_seed;
               if (exp_ff == '0) begin
                  rsp_in.power_result  = DATA_W'(acc_seed);
                  rsp_in.modulus_error = 1'b0;
                  rsp_valid_in         = 1'b1;
                  state_in             = ST_IDLE;
               end else begin
                  state_in = ST_NEXT;
               end
            end
         end
         ST_NEXT: begin
            // Launch a multiply on a set bit, else go straight to the square
            mul_ctl.start = 1'b1;
            if (exp_ff[0]) begin
               mul_a    = acc_ff;
               mul_b    = base_ff;
               state_in = ST_MULT;
            end else begin
               mul_a    = base_ff;
               mul_b    = base_ff;
               state_in = ST_SQUARE;
            end
         end
         ST_MULT: begin
            if (mul_sts.done) begin
               acc_in = mul_res;
               if (exp_rest == '0) begin
                  // Top set bit consumed: the last square is not needed
                  rsp_in.power_result  = DATA_W'(mul_res);
                  rsp_in.modulus_error = 1'b0;
                  rsp_valid_in         = 1'b1;
                  state_in             = ST_IDLE;
               end else begin
                  mul_ctl.start = 1'b1;
                  mul_a         = base_ff;
                  mul_b         = base_ff;
                  state_in      = ST_SQUARE;
               end
            end
         end
         ST_SQUARE: begin
            if (mul_sts.done) begin
               base_in  = mul_res;
               exp_in   = exp_rest;
               state_in = ST_NEXT;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         modulus_ff   <= WIDTH'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         modulus_ff   <= modulus_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath holds need no reset
   always_ff @(posedge clock) begin
      exp_ff  <= exp_in;
      base_ff <= base_in;
      acc_ff  <= acc_in;
      rsp_ff  <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Check terms: a request that starts the multiplier, states that wait on a
   // product, and an error strobe
   assign run_accept = start && !busy && (modulus_ff != '0);
   assign mul_wait   = state_ff inside {ST_REDUCE, ST_MULT, ST_SQUARE};
   assign rsp_err    = rsp_valid && rsp_data.modulus_error;

   `MXP_ASSERT_NOW(a_launch_free, clock, reset, mul_ctl.start, !mul_sts.busy, "launch while busy")
   `MXP_ASSERT_NEXT(a_accept_busy, clock, reset, run_accept, busy, "request not started")
   `MXP_ASSERT_NOW(a_error_zero, clock, reset, rsp_err, ~|rsp_data.power_result, "error with data")
   `MXP_ASSERT_NOW(a_done_waited, clock, reset, mul_sts.done, mul_wait, "product unexpected")

endmodule

[hdl/mxp_mulmod.sv]
// Bit-serial modular multiplier: one multiplier bit per cycle, MSB first
`timescale 1ns / 1ps

`include "modular_exponentiation_core_macros.svh"

module mxp_mulmod #(
   parameter int WIDTH = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  mxp_pkg::mul_ctl_type ctl,
   input  logic [WIDTH-1:0]    opa,
   input  logic [WIDTH-1:0]    opb,
   input  logic [WIDTH-1:0]    modulus,
   output mxp_pkg::mul_sts_type sts,
   output logic [WIDTH-1:0]    result
);
   import mxp_pkg::*;

   localparam int CNT_W = $clog2(WIDTH + 1);
   localparam int SUM_W = WIDTH + 2;

   logic [WIDTH-1:0] a_ff, a_in;
   logic [WIDTH-1:0] b_ff, b_in;
   logic [WIDTH-1:0] m_ff, m_in;
   logic [WIDTH-1:0] acc_ff, acc_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [SUM_W-1:0] sum;
   logic [SUM_W-1:0] m1;
   logic [SUM_W-1:0] m2;
   logic [WIDTH-1:0] step;

   // 2*acc + bit*a stays below 3m: subtract 0, m or 2m
   always_comb begin
      m1  = {2'b00, m_ff};
      m2  = {1'b0, m_ff, 1'b0};
      sum = {1'b0, acc_ff, 1'b0} + (b_ff[WIDTH-1] ? {2'b00, a_ff} : '0);
      if (sum >= m2) begin
         step = WIDTH'(sum - m2);
      end else if (sum >= m1) begin
         step = WIDTH'(sum - m1);
      end else begin
         step = WIDTH'(sum);
      end
   end

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      m_in    = m_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctl.start) begin
         a_in    = opa;
         b_in    = opb;
         m_in    = modulus;
         acc_in  = '0;
         cnt_in  = CNT_W'(WIDTH);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = step;
         b_in   = b_ff << 1;
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      m_ff   <= m_in;
      acc_ff <= acc_in;
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign result   = acc_ff;

   `MXP_ASSERT_NEXT(a_start_runs, clock, reset, ctl.start, busy_ff, "multiplier did not start")
   `MXP_ASSERT_NOW(a_result_reduced, clock, reset, done_ff, acc_ff < m_ff, "product not reduced")
   `MXP_ASSERT_NOW(a_done_not_busy, clock, reset, done_ff, !busy_ff, "done while still stepping")

endmodule
